// ----- hdl/sorted_segment_range_table_core_defines.svh -----
// Assertion macros shared by the segment table RTL.
`ifndef SORTED_SEGMENT_RANGE_TABLE_CORE_DEFINES_SVH
`define SORTED_SEGMENT_RANGE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SSTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sstc check failed");

// Next-cycle implication, checked out of reset.
`define SSTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sstc check failed");

`endif

// ----- hdl/sstc_pkg.sv -----
// Types and constants of the sorted segment range table.
`timescale 1ns / 1ps
package sstc_pkg;
    localparam int MAX_SEGMENTS = 16;
    localparam int ADDR_W       = 48;
    localparam int PAGE_BITS    = 12;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int OFS_W        = 48;
    localparam int PROT_W       = 4;

    localparam logic [ADDR_W-1:0] AMAX      = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0] PAGE_MASK = AMAX >> (ADDR_W - PAGE_BITS);

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_INSERT   = 2'd1;
    localparam logic [1:0] OP_CONTAINS = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_OVERLAP = 2'd2;
    localparam logic [1:0] STAT_RANGE   = 2'd3;

    localparam logic [1:0] REG_PAGE_ALIGN = 2'd0;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] seg_start;
        logic [ADDR_W-1:0] seg_size;
        logic [PROT_W-1:0] seg_prot;
        logic              seg_shared;
        logic [OFS_W-1:0]  seg_offset;
        logic [ADDR_W-1:0] query_addr;
        logic [IDX_W-1:0]  entry_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              hit;
        logic              is_contiguous;
        logic [CNT_W-1:0]  entry_count;
        logic [ADDR_W-1:0] out_start;
        logic [ADDR_W-1:0] out_end;
        logic [PROT_W-1:0] out_prot;
    } out_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] seg_start;
        logic [ADDR_W-1:0] seg_end;
        logic [PROT_W-1:0] prot;
        logic              shared;
        logic [OFS_W-1:0]  offset;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROUND,
        S_SCAN,
        S_CHECK,
        S_SHIFT,
        S_WRITE,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } state_t;
endpackage

// ----- hdl/sstc_if.sv -----
// Valid/ready channel interfaces for the segment table input and result words.
`timescale 1ns / 1ps
interface sstc_in_if import sstc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sstc_out_if import sstc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/sstc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sstc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hdl/sorted_segment_range_table_core.sv -----
// Sorted segment table: clear, insert, contains and read-nth over a single entry RAM.
// Insert rounds the bounds, scans for the insertion point, checks for overlap,
// shifts later entries up and writes the new one; contains scans all valid entries;
// read-nth reads one entry.
// Rate: one word at a time; a new word is accepted only in the idle state.
// Reset: entry count 0, contiguous flag 1, page alignment on; RAM is not cleared.
`timescale 1ns / 1ps
`include "sorted_segment_range_table_core_defines.svh"
module sorted_segment_range_table_core import sstc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    sstc_in_if.sink            in_ch,
    sstc_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    state_t state_reg, state_next;

    in_word_t          req_reg;
    logic [ADDR_W:0]   sum_reg;
    logic [ADDR_W-1:0] ns_reg, e_reg;
    logic [CNT_W-1:0]  count_reg, iss_reg, pos_reg;
    logic              contig_reg, page_en_reg;
    logic              pend_reg, found_reg, hit_reg;
    logic [IDX_W-1:0]  pidx_reg;
    logic [ADDR_W-1:0] prev_end_reg, next_start_reg;
    logic [1:0]        status_reg;
    entry_t            rd_ent_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;

    logic              in_acc, out_load;
    logic              overlap, gap;
    logic [ADDR_W-1:0] pm, e0, lim, rnd, e_new;
    logic [CNT_W-1:0]  iss_dec;

    assign ram_rdata = entry_t'(ram_rbits);

    sstc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign pready     = 1'b1;
    assign prdata     = {31'b0, page_en_reg};
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc     = in_ch.valid && (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    // Bound rounding; the end saturates to the largest address.
    assign pm    = page_en_reg ? PAGE_MASK : '0;
    assign e0    = sum_reg[ADDR_W] ? AMAX : sum_reg[ADDR_W-1:0];
    assign lim   = AMAX - pm;
    assign rnd   = (e0 + pm) & ~pm;
    assign e_new = ((e0 == AMAX) || (e0 > lim)) ? AMAX : rnd;

    assign overlap = ((pos_reg != '0) && (ns_reg < prev_end_reg)) ||
                     (found_reg && (next_start_reg < e_reg));
    assign gap     = ((pos_reg != '0) && (ns_reg > prev_end_reg)) ||
                     (found_reg && (next_start_reg > e_reg));
    assign iss_dec = iss_reg - 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_ch.data.op)
                        OP_INSERT:
                        begin
                            if (count_reg >= CNT_W'(MAX_SEGMENTS))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ROUND;
                            end
                        end
                        OP_CONTAINS: state_next = S_SCAN;
                        OP_READ:     state_next = S_READ;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_ROUND: state_next = S_SCAN;
            S_SCAN:
            begin
                if (!ram_re && !pend_reg)
                begin
                    state_next = (req_reg.op == OP_INSERT) ? S_CHECK : S_DONE;
                end
            end
            S_CHECK: state_next = overlap ? S_DONE : S_SHIFT;
            S_SHIFT:
            begin
                if (!ram_re && !pend_reg)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: state_next = S_DONE;
            S_READ:  state_next = ram_re ? S_READ_WAIT : S_DONE;
            S_READ_WAIT: state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // RAM controls.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = iss_reg[IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = pidx_reg + 1'b1;
        ram_wdata = ram_rdata;
        case (state_reg)
            S_SCAN:
            begin
                ram_re = (iss_reg < count_reg);
            end
            S_SHIFT:
            begin
                ram_re    = (iss_reg > pos_reg);
                ram_raddr = iss_dec[IDX_W-1:0];
                ram_we    = pend_reg;
            end
            S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[IDX_W-1:0];
                ram_wdata = '{seg_start: ns_reg, seg_end: e_reg, prot: req_reg.seg_prot,
                              shared: req_reg.seg_shared, offset: req_reg.seg_offset};
            end
            S_READ:
            begin
                ram_re    = ({1'b0, req_reg.entry_index} < count_reg);
                ram_raddr = req_reg.entry_index;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            contig_reg    <= 1'b1;
            page_en_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && (paddr == REG_PAGE_ALIGN))
            begin
                page_en_reg <= pwdata[0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_acc && (in_ch.data.op == OP_CLEAR))
            begin
                count_reg  <= '0;
                contig_reg <= 1'b1;
            end
            if (state_reg == S_WRITE)
            begin
                count_reg <= count_reg + 1'b1;
                if (gap)
                begin
                    contig_reg <= 1'b0;
                end
            end
            pend_reg <= ram_re && ((state_reg == S_SCAN) || (state_reg == S_SHIFT));
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg    <= in_ch.data;
            sum_reg    <= {1'b0, in_ch.data.seg_start} + {1'b0, in_ch.data.seg_size};
            status_reg <= ((in_ch.data.op == OP_INSERT) &&
                           (count_reg >= CNT_W'(MAX_SEGMENTS))) ? STAT_FULL : STAT_OK;
            hit_reg    <= 1'b0;
            rd_ent_reg <= '0;
            iss_reg    <= '0;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
            ns_reg     <= in_ch.data.query_addr;
        end
        if (state_reg == S_ROUND)
        begin
            ns_reg <= req_reg.seg_start & ~pm;
            e_reg  <= e_new;
        end
        if (state_reg == S_SCAN)
        begin
            if (ram_re)
            begin
                iss_reg <= iss_reg + 1'b1;
            end
            pidx_reg <= iss_reg[IDX_W-1:0];
            if (pend_reg)
            begin
                // Contains query holds the address in ns_reg.
                if ((ns_reg >= ram_rdata.seg_start) && (ns_reg < ram_rdata.seg_end))
                begin
                    hit_reg <= 1'b1;
                end
                if (ram_rdata.seg_start <= ns_reg)
                begin
                    pos_reg      <= {1'b0, pidx_reg} + 1'b1;
                    prev_end_reg <= ram_rdata.seg_end;
                end
                else if (!found_reg)
                begin
                    found_reg      <= 1'b1;
                    next_start_reg <= ram_rdata.seg_start;
                end
            end
        end
        if (state_reg == S_CHECK)
        begin
            iss_reg <= count_reg;
            if (overlap)
            begin
                status_reg <= STAT_OVERLAP;
            end
        end
        if (state_reg == S_SHIFT)
        begin
            if (ram_re)
            begin
                iss_reg <= iss_dec;
            end
            pidx_reg <= iss_dec[IDX_W-1:0];
        end
        if ((state_reg == S_READ) && !ram_re)
        begin
            status_reg <= STAT_RANGE;
        end
        if (state_reg == S_READ_WAIT)
        begin
            rd_ent_reg <= ram_rdata;
        end
        if (out_load)
        begin
            out_data_reg.status        <= status_reg;
            out_data_reg.hit           <= (req_reg.op == OP_CONTAINS) && hit_reg;
            out_data_reg.is_contiguous <= contig_reg;
            out_data_reg.entry_count   <= count_reg;
            out_data_reg.out_start     <= rd_ent_reg.seg_start;
            out_data_reg.out_end       <= rd_ent_reg.seg_end;
            out_data_reg.out_prot      <= rd_ent_reg.prot;
        end
    end

    `SSTC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_SEGMENTS))
    `SSTC_ASSERT_NOW(a_write_states, ram_we, (state_reg == S_SHIFT) || (state_reg == S_WRITE))
    `SSTC_ASSERT_NEXT(a_accept_busy, in_acc, state_reg != S_IDLE)
endmodule
